@@ rtl/core/rpcl_pkg.sv @@
package rpcl_pkg;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int WAY_OUT_W = 2;

    // access clock and reuse interval
    localparam int CLOCK_W = 31;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX        = '1;
    localparam logic [CLOCK_W-1:0] UNKNOWN_INTERVAL = 31'd999999;

    // default geometry, all powers of two
    localparam int DEF_NUM_SETS    = 64;
    localparam int DEF_NUM_WAYS    = 4;
    localparam int DEF_BLOCK_BYTES = 64;

endpackage

@@ rtl/core/reuse_predict_cache_lookup_core.sv @@
// a taken request registers its memory row; the lookup step then writes the row back and registers the result
// one request in flight at a time, for the read-modify-write of one memory row
// a result that waits on rsp_stall holds the lookup step, so the next request waits too
// reset: asynchronous, active low; clears control state, then a clearing pass writes the NUM_SETS
// rows in turn and invalidates every row while req_stall stays high
// NUM_SETS and BLOCK_BYTES must be powers of two; the block itself does not enforce this
module reuse_predict_cache_lookup_core
    import rpcl_pkg::*;
#(
    parameter int NUM_SETS    = DEF_NUM_SETS,
    parameter int NUM_WAYS    = DEF_NUM_WAYS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [ADDR_W-1:0]    address,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way
);

    // address split
    localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS    = $clog2(NUM_SETS);
    localparam int SET_W       = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS - SET_BITS;

    // way index and victim tree
    localparam int WAY_BITS = $clog2(NUM_WAYS);
    localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int LEAVES   = 1 << WAY_BITS;
    localparam int NODES    = 2 * LEAVES - 1;

    // estimate: last + interval - now, kept signed and wide enough never to overflow
    localparam int DIFF_W = CLOCK_W + 3;
    localparam int EST_W  = CLOCK_W + 2;

    // one line of the tag store
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [CLOCK_W-1:0] last;
        logic [CLOCK_W-1:0] interval;
    } line_t;

    typedef line_t [NUM_WAYS-1:0] row_t;

    // one candidate in the victim tournament
    typedef struct packed {
        logic             ok;
        logic [EST_W-1:0] est;
        logic [WAY_W-1:0] idx;
    } cand_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [SET_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [CLOCK_W-1:0] clock_reg, clock_next;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    row_t               rd_row_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               hit_reg;
    logic [WAY_W-1:0]   way_reg;

    // set memory, one row of NUM_WAYS lines per set
    row_t mem [NUM_SETS];

    logic [ADDR_W-1:0]  addr_set_shift;
    logic [ADDR_W-1:0]  addr_tag_shift;
    logic [SET_W-1:0]   req_set;
    logic               req_take;
    logic               commit;
    logic [CLOCK_W-1:0] now;

    logic               hit_any;
    logic [WAY_W-1:0]   hit_idx;
    logic               inv_any;
    logic [WAY_W-1:0]   inv_idx;
    logic [EST_W-1:0]   est [LEAVES];
    cand_t              node [NODES];
    logic [WAY_W-1:0]   sel_idx;
    row_t               row_wr;

    logic               mem_we;
    logic [SET_W-1:0]   mem_waddr;
    row_t               mem_wdata;

    // request side: one request in flight, taken only in idle
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;

    // set and tag from the byte address
    assign addr_set_shift = address >> OFFSET_BITS;
    assign addr_tag_shift = address >> (OFFSET_BITS + SET_BITS);
    assign req_set        = (SET_BITS > 0) ? addr_set_shift[SET_W-1:0] : '0;

    // lookup step completes once the output register is free or being emptied
    assign commit = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || !rsp_stall);

    // saturating access clock, advanced by each access
    assign now = (clock_reg == CLOCK_MAX) ? clock_reg : clock_reg + 1'b1;

    // hit search and first invalid way, lowest way wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        inv_any = 1'b0;
        inv_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (rd_row_reg[w].valid && (rd_row_reg[w].tag == tag_reg))
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!rd_row_reg[w].valid)
            begin
                inv_any = 1'b1;
                inv_idx = WAY_W'(w);
            end
        end
    end

    // estimated time to reuse per way; a negative estimate reads as unknown
    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        diff = '0;
        for (int w = 0; w < LEAVES; w++)
        begin
            est[w] = '0;
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            diff = $signed(DIFF_W'(rd_row_reg[w].last))
                 + $signed(DIFF_W'(rd_row_reg[w].interval))
                 - $signed(DIFF_W'(now));
            est[w] = diff[DIFF_W-1] ? EST_W'(UNKNOWN_INTERVAL) : diff[EST_W-1:0];
        end
    end

    // tournament for the largest estimate, left (lower way) keeps ties
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            node[LEAVES-1+i].ok  = (i < NUM_WAYS);
            node[LEAVES-1+i].est = est[i];
            node[LEAVES-1+i].idx = WAY_W'(i);
        end
        for (int n = LEAVES - 2; n >= 0; n--)
        begin
            if (node[2*n+2].ok && (!node[2*n+1].ok || (node[2*n+2].est > node[2*n+1].est)))
            begin
                node[n] = node[2*n+2];
            end
            else
            begin
                node[n] = node[2*n+1];
            end
        end
    end

    // update the row read for this request
    always_comb
    begin
        row_wr = rd_row_reg;
        if (hit_any)
        begin
            sel_idx = hit_idx;
            // elapsed time wraps to 31 bits
            row_wr[hit_idx].interval = now - rd_row_reg[hit_idx].last;
            row_wr[hit_idx].last     = now;
        end
        else
        begin
            sel_idx = inv_any ? inv_idx : node[0].idx;
            row_wr[sel_idx].valid    = 1'b1;
            row_wr[sel_idx].tag      = tag_reg;
            row_wr[sel_idx].last     = now;
            row_wr[sel_idx].interval = UNKNOWN_INTERVAL;
        end
    end

    // write port: clearing pass, then write-back of the lookup
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = row_wr;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (commit)
        begin
            mem_we = 1'b1;
        end
    end

    // the write-back lands before the next request can read, so no forwarding
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (req_take)
        begin
            rd_row_reg <= mem[req_set];
        end
    end

    // request payload held for the lookup step
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            set_reg <= req_set;
            tag_reg <= addr_tag_shift[TAG_W-1:0];
        end
        if (commit)
        begin
            hit_reg <= hit_any;
            way_reg <= sel_idx;
        end
    end

    // control next state
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        clock_next     = clock_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    clock_next     = now;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            clock_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clock_reg     <= clock_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result side
    assign rsp_valid = rsp_valid_reg;
    assign hit       = hit_reg;
    assign way       = WAY_OUT_W'(way_reg);

endmodule

@@ rtl/core/rpcl_checker.sv @@
module rpcl_checker
    import rpcl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input logic                 hit,
    input logic [WAY_OUT_W-1:0] way
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(hit) && $stable(way))
        else $error("stalled result changed");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while one in flight");

    // a taken request is followed by a valid result on the output, its own or one still held by rsp_stall
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##2 rsp_valid)
        else $error("result missing after request");

    // a new result only follows a taken request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("result without request");

endmodule

bind reuse_predict_cache_lookup_core rpcl_checker u_rpcl_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
    import rpcl_pkg::*;

    // geometry under test, the block defaults
    localparam int SETS  = DEF_NUM_SETS;
    localparam int WAYS  = DEF_NUM_WAYS;
    localparam int BLOCK = DEF_BLOCK_BYTES;
    localparam int LINES = SETS * WAYS;
    localparam int OFF_W = $clog2(BLOCK);
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = ADDR_W - OFF_W - SET_W;

    // run length and watchdog
    localparam int RANDOM_REQS  = 1200;
    localparam int PHASE_LEN    = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 20;
    localparam int MAX_REPORTS  = 10;

    // traffic shape per phase: who idles and how often
    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [ADDR_W-1:0] address;
        pace_t             pace;
        bit                drain;
    } access_req_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
    } lookup_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [ADDR_W-1:0]    address   = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;

    // requests not yet offered, and lookups still owed by the block
    access_req_t pending_reqs[$];
    lookup_t     owed_lookups[$];

    bit req_taken     = 1'b0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int mismatches    = 0;
    int results_seen  = 0;

    // shadow tag store
    logic [TAG_W-1:0]   shadow_tag   [LINES];
    bit                 shadow_valid [LINES];
    logic [CLOCK_W-1:0] shadow_last  [LINES];
    logic [CLOCK_W-1:0] shadow_ival  [LINES];
    logic [CLOCK_W-1:0] access_time;

    reuse_predict_cache_lookup_core #(
        .NUM_SETS    (SETS),
        .NUM_WAYS    (WAYS),
        .BLOCK_BYTES (BLOCK)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .address   (address),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .way       (way)
    );

    always #10 clk = ~clk;

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [TAG_W-1:0] t,
                                                  input logic [SET_W-1:0] s,
                                                  input logic [OFF_W-1:0] o);
        return {t, s, o};
    endfunction

    // look up one address in the shadow store and update it the way the
    // replacement policy does: hit refreshes the reuse interval, miss fills
    // the lowest invalid way or the way expected to be reused last
    function automatic lookup_t lookup_and_update(input logic [ADDR_W-1:0] a);
        int unsigned      set_idx;
        int unsigned      base;
        int unsigned      victim;
        logic [TAG_W-1:0] tag;
        longint           best;
        longint           etr;
        lookup_t          res;
        bit               found;
        set_idx = (a >> OFF_W) % SETS;
        tag     = TAG_W'(a >> (OFF_W + SET_W));
        base    = set_idx * WAYS;
        victim  = 0;
        best    = -1;
        found   = 1'b0;
        res     = '0;
        // access clock saturates at its ceiling
        if (access_time != CLOCK_MAX)
            access_time++;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag)
            begin
                shadow_ival[base + w] = access_time - shadow_last[base + w];
                shadow_last[base + w] = access_time;
                res.hit = 1'b1;
                res.way = WAY_OUT_W'(w);
                found   = 1'b1;
            end
        end
        if (!found)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!shadow_valid[base + w])
                begin
                    victim = w;
                    break;
                end
                // estimate in wide signed arithmetic, overdue lines look far away
                etr = longint'(shadow_last[base + w]) + longint'(shadow_ival[base + w])
                      - longint'(access_time);
                if (etr < 0)
                    etr = longint'(UNKNOWN_INTERVAL);
                // strict compare keeps the lowest way on ties
                if (etr > best)
                begin
                    best   = etr;
                    victim = w;
                end
            end
            shadow_tag[base + victim]   = tag;
            shadow_valid[base + victim] = 1'b1;
            shadow_last[base + victim]  = access_time;
            shadow_ival[base + victim]  = UNKNOWN_INTERVAL;
            res.hit = 1'b0;
            res.way = WAY_OUT_W'(victim);
        end
        return res;
    endfunction

    task automatic queue_access(input logic [ADDR_W-1:0] a, input pace_t p, input bit d);
        access_req_t r;
        r.address = a;
        r.pace    = p;
        r.drain   = d;
        pending_reqs.push_back(r);
    endtask

    // driver: all inputs move on the falling edge; a request stays put
    // until the block takes it
    always @(negedge clk)
    begin : drive_reqs
        access_req_t nxt;
        bit          send;
        int          idle_pct;
        if (rst_n)
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            if (!req_valid || req_taken)
            begin
                send = 1'b0;
                if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs[0];
                    case (nxt.pace)
                        PACE_SENDER_IDLE: idle_pct = 70;
                        PACE_BOTH:        idle_pct = 35;
                        default:          idle_pct = 0;
                    endcase
                    send = 1'b1;
                    // drain point: hold off until the block owes nothing
                    if (nxt.drain && owed_lookups.size() != 0)
                        send = 1'b0;
                    if ($urandom_range(99) < idle_pct)
                        send = 1'b0;
                    if (send)
                    begin
                        void'(pending_reqs.pop_front());
                        case (nxt.pace)
                            PACE_RECV_STALL: stall_pct <= 70;
                            PACE_BOTH:       stall_pct <= 35;
                            default:         stall_pct <= 0;
                        endcase
                        address <= nxt.address;
                    end
                end
                req_valid <= send;
            end
        end
    end

    // monitor: handshakes are judged on the rising edge with pre-edge values
    always @(posedge clk)
    begin : watch_ports
        lookup_t want;
        cycle_count <= cycle_count + 1;
        req_taken   <= req_valid && !req_stall && rst_n;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen <= results_seen + 1;
            if (owed_lookups.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected lookup result %0d: hit=%0d way=%0d",
                             results_seen, hit, way);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = owed_lookups.pop_front();
                if (hit !== want.hit || way !== want.way)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("lookup %0d mismatch: expected hit=%0d way=%0d, got hit=%0d way=%0d",
                                 results_seen, want.hit, want.way, hit, way);
                    mismatches <= mismatches + 1;
                end
            end
        end
        // request accepted: work out its lookup now, in request order
        if (rst_n && req_valid && !req_stall)
            owed_lookups.push_back(lookup_and_update(address));
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [SET_W-1:0] hot_sets [4];
        logic [TAG_W-1:0] tag_pool [6];
        logic [TAG_W-1:0] tg;
        logic [ADDR_W-1:0] a;
        int               pick;
        pace_t            pace;

        for (int i = 0; i < LINES; i++)
        begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_last[i]  = '0;
            shadow_ival[i]  = UNKNOWN_INTERVAL;
        end
        access_time = '0;

        // directed: address extremes, hit after fill
        queue_access(32'h0000_0000, PACE_STEADY, 1'b0);
        queue_access(32'h0000_0000, PACE_STEADY, 1'b0);
        queue_access(32'hFFFF_FFFF, PACE_STEADY, 1'b0);
        queue_access(32'hFFFF_FFC0, PACE_STEADY, 1'b0);
        // fill every way of one set through the invalid ways
        for (int t = 1; t <= 4; t++)
            queue_access(mk_addr(TAG_W'(t), 5, 0), PACE_STEADY, 1'b0);
        // short reuse interval on way 0, then a full-set eviction
        queue_access(mk_addr(1, 5, 3), PACE_STEADY, 1'b0);
        queue_access(mk_addr(1, 5, 7), PACE_STEADY, 1'b0);
        queue_access(mk_addr(5, 5, 0), PACE_STEADY, 1'b0);
        queue_access(mk_addr(2, 5, 0), PACE_STEADY, 1'b0);
        queue_access(mk_addr(3, 5, 0), PACE_STEADY, 1'b0);
        // by now the short-interval line is overdue, so its estimate goes negative
        queue_access(mk_addr(6, 5, 0), PACE_STEADY, 1'b0);
        queue_access(mk_addr('1, 5, '1), PACE_STEADY, 1'b0);
        queue_access(mk_addr(1, 5, 0), PACE_STEADY, 1'b0);
        queue_access(mk_addr(0, '1, 0), PACE_STEADY, 1'b0);
        queue_access(mk_addr(20'hAAAAA, 6'h2A, 6'h15), PACE_STEADY, 1'b0);
        queue_access(mk_addr(20'h55555, 6'h15, 6'h2A), PACE_STEADY, 1'b0);

        // random: a few hot sets and a small tag pool so hits, fills and
        // evictions all happen often; the rest is scattered noise
        for (int i = 0; i < 6; i++)
            tag_pool[i] = TAG_W'($urandom);
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                for (int s = 0; s < 4; s++)
                    hot_sets[s] = SET_W'($urandom);
                tag_pool[$urandom_range(5)] = TAG_W'($urandom);
            end
            pace = pace_t'((i / PHASE_LEN) % 4);
            pick = $urandom_range(99);
            if (pick < 10)
                a = $urandom;
            else
            begin
                tg = (pick < 20) ? TAG_W'($urandom) : tag_pool[$urandom_range(5)];
                a  = mk_addr(tg, hot_sets[$urandom_range(3)], OFF_W'($urandom));
            end
            queue_access(a, pace, i % PHASE_LEN == 0);
        end

        // single reset; the block then runs its clearing pass behind req_stall
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_valid)
            @(negedge clk);
        while (owed_lookups.size() > 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);

        if (mismatches == 0 && owed_lookups.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
